// ===== src/oale_pkg.sv =====
// Shared types and constants for the ordered array list engine.
// Holds the request and status codes and the control word that goes to every cell.
// Depends on nothing; every module of the block imports it.
package oale_pkg;

	// Request codes carried on the kind port; code 7 is ignored
	typedef enum logic [2:0] {
		KIND_PUSH_BACK  = 3'd0,
		KIND_POP_BACK   = 3'd1,
		KIND_PUSH_FRONT = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_INSERT     = 3'd4,
		KIND_ERASE      = 3'd5,
		KIND_FIND       = 3'd6
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EMPTY   = 2'd2,
		STATUS_BAD_POS = 2'd3
	} status_t;

	// Widest cell index and count for the largest supported depth of 256
	localparam int POS_BITS = 8;
	localparam int CNT_BITS = 9;

	// Match bits examined per scan cycle, and width of the found_index port
	localparam int SCAN_LANES     = 8;
	localparam int LANE_BITS      = 3;
	localparam int FOUND_IDX_BITS = 4;

	// Control word broadcast to the cell row
	typedef struct packed {
		logic                ins;  // open a gap at pos and load the new word
		logic                del;  // close the gap at pos
		logic [POS_BITS-1:0] pos;  // gap position
		logic [CNT_BITS-1:0] cnt;  // number of live entries
	} cell_ctl_t;

endpackage

// ===== src/oale_cell.sv =====
// One cell of the list row: holds a single entry and compares it with a key.
// Takes its neighbor's word on an insert or erase that moves it.
// Depends on oale_pkg for the control word.
module oale_cell #(
	parameter int WORD_BITS = 32,
	parameter int IDX       = 0
) (
	input  logic                      clk,
	input  oale_pkg::cell_ctl_t       ctl,
	input  logic [WORD_BITS-1:0]      word,
	input  logic [WORD_BITS-1:0]      left,
	input  logic [WORD_BITS-1:0]      right,
	input  logic [WORD_BITS-1:0]      key,
	output logic [WORD_BITS-1:0]      data,
	output logic                      match
);
	import oale_pkg::*;

	localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(IDX);
	localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(IDX);

	logic [WORD_BITS-1:0] data_q;
	logic                 at_gap;
	logic                 past_gap;

	assign at_gap   = ctl.pos == MY_POS;
	assign past_gap = MY_POS > ctl.pos;

	// Shift up past an insert gap, load at the gap, shift down from an erase gap
	always_ff @(posedge clk) begin
		if (ctl.ins && past_gap) begin
			data_q <= left;
		end else if (ctl.ins && at_gap) begin
			data_q <= word;
		end else if (ctl.del && (past_gap || at_gap)) begin
			data_q <= right;
		end
	end

	// Flag a live entry equal to the key
	assign match = (data_q == key) && (MY_CNT < ctl.cnt);
	assign data  = data_q;

endmodule

// ===== src/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: request decode, count, cell row, find scan.
// Depends on oale_pkg and oale_cell.
//
//   channel   | handshake            | fields
//   ----------+----------------------+------------------------------------
//   request   | start, busy          | kind, position, value
//   result    | done (one cycle)     | status, found, found_index, count
//
// Every request except a find on a non-empty list returns its word in the cycle after
// acceptance, and busy stays low, so a new request may follow in every cycle.
// A find registers the match bits of all cells at acceptance and then scans them
// eight per cycle, with busy high until the result cycle.
// Reset clears the count and the control state; cell contents need no reset.
// The result cannot be stalled: done is high for exactly one cycle per request.
module ordered_array_list_engine #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [3:0]  found_index,
	output logic [4:0]  count
);
	import oale_pkg::*;

	localparam int CNTW   = $clog2(DEPTH + 1);
	localparam int CMPW   = (CNTW > 5) ? CNTW : 5;
	localparam int NCHUNK = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
	localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int SIW    = CW + LANE_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                            state_q, state_d;
	logic [CNTW-1:0]                   count_q, count_d;
	logic [CW-1:0]                     chunk_q;
	logic [NCHUNK-1:0][SCAN_LANES-1:0] match_s1;
	logic [NCHUNK-1:0][SCAN_LANES-1:0] match_pad;
	logic                              done_q;
	status_t                           status_q, status_d;
	logic                              found_q;
	logic [FOUND_IDX_BITS-1:0]         fidx_q;

	logic                              accept;
	logic                              full;
	logic                              empty;
	logic                              scan_start;
	cell_ctl_t                         ctl;
	logic [WORD_BITS-1:0]              new_word;
	logic [WORD_BITS-1:0]              cell_data [DEPTH];
	logic [DEPTH-1:0]                  match_vec;
	logic [SCAN_LANES-1:0]             lane_bits;
	logic                              lane_any;
	logic [LANE_BITS-1:0]              lane_idx;
	logic [SIW-1:0]                    scan_idx;
	logic                              last_chunk;

	assign accept   = start && !busy;
	assign busy     = state_q == ST_SCAN;
	assign full     = count_q == CNTW'(DEPTH);
	assign empty    = count_q == '0;
	assign new_word = WORD_BITS'($unsigned(value));

	// Decode the request: status, next count and the cell control word
	always_comb begin
		ctl        = '0;
		ctl.cnt    = CNT_BITS'(count_q);
		status_d   = STATUS_OK;
		count_d    = count_q;
		scan_start = 1'b0;
		case (kind_t'(kind))
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					ctl.ins = 1'b1;
					ctl.pos = POS_BITS'(count_q);
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					ctl.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					ctl.del = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			KIND_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else if (CMPW'(position) > CMPW'(count_q)) begin
					status_d = STATUS_BAD_POS;
				end else begin
					ctl.ins = 1'b1;
					ctl.pos = POS_BITS'(position);
					count_d = count_q + 1'b1;
				end
			end
			KIND_ERASE: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else if (CMPW'(position) >= CMPW'(count_q)) begin
					status_d = STATUS_BAD_POS;
				end else begin
					ctl.del = 1'b1;
					ctl.pos = POS_BITS'(position);
					count_d = count_q - 1'b1;
				end
			end
			KIND_FIND: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					scan_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Drop the moves of a request that is not taken
		if (!accept) begin
			ctl.ins = 1'b0;
			ctl.del = 1'b0;
		end
	end

	// Cell row: each cell sees its neighbors; the first takes the new word from the left, the last sees zero on the right
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		oale_cell #(
			.WORD_BITS(WORD_BITS),
			.IDX      (i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.word (new_word),
			.left (left_w),
			.right(right_w),
			.key  (new_word),
			.data (cell_data[i]),
			.match(match_vec[i])
		);
	end

	// Pad the match bits out to whole scan chunks
	always_comb begin
		match_pad = (NCHUNK * SCAN_LANES)'(match_vec);
	end

	// Priority-encode the current chunk
	always_comb begin
		lane_bits = match_s1[chunk_q];
		lane_any  = |lane_bits;
		lane_idx  = '0;
		for (int j = SCAN_LANES - 1; j >= 0; j--) begin
			if (lane_bits[j]) begin
				lane_idx = LANE_BITS'(j);
			end
		end
	end

	assign scan_idx   = {chunk_q, lane_idx};
	assign last_chunk = chunk_q == CW'(NCHUNK - 1);

	// Advance the state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && scan_start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (lane_any || last_chunk) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: state, count, scan position, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			chunk_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_d;
				chunk_q <= '0;
				done_q  <= !scan_start;
			end else if (busy) begin
				chunk_q <= chunk_q + 1'b1;
				done_q  <= lane_any || last_chunk;
			end else begin
				done_q  <= 1'b0;
			end
		end
	end

	// Result word and captured match bits
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			found_q  <= 1'b0;
			fidx_q   <= '0;
			match_s1 <= match_pad;
		end else if (busy) begin
			found_q <= lane_any;
			fidx_q  <= lane_any ? FOUND_IDX_BITS'(scan_idx) : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign found_index = fidx_q;
	assign count       = 5'(count_q);

	// The count never runs past the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("count above depth");

	// A request that needs no scan reports in the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !scan_start |=> done && !busy)
		else $error("missing result after request");

	// A hit is only ever reported with an ok status and a live index
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == STATUS_OK && CNT_BITS'(found_index) < CNT_BITS'(count))
		else $error("bad found result");

	// The count holds while a scan runs
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(count_q))
		else $error("count moved during scan");

	// No result strobe while a scan still runs
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) |-> !done)
		else $error("result during scan");

endmodule

// ===== test/oale_result_checker.sv =====
// Result checker for the ordered array list engine: tracks the list contents and
// count, predicts the result word of every accepted request and compares it.
// Depends on oale_pkg for the request and status codes.
module oale_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic        found,
	input  logic [3:0]  found_index,
	input  logic [4:0]  count,
	output int          fail_count,
	output int          pending_words
);
	import oale_pkg::*;

	localparam int LIST_DEPTH = 16;

	typedef struct {
		status_t    status;
		logic       found;
		logic [3:0] found_index;
		logic [4:0] count;
	} list_result_t;

	logic [31:0]  list_words [LIST_DEPTH];
	int           list_len;
	list_result_t results_due [$];

	// Move entries at and above the slot up by one and load the new word
	task automatic open_slot(input int at, input logic [31:0] word);
		int i;
		for (i = list_len; i > at; i--)
			list_words[i] = list_words[i - 1];
		list_words[at] = word;
		list_len++;
	endtask

	// Move entries above the slot down by one
	task automatic close_slot(input int at);
		int i;
		for (i = at; i + 1 < list_len; i++)
			list_words[i] = list_words[i + 1];
		list_len--;
	endtask

	// Apply one request to the shadow list and queue the result word it must give
	task automatic apply_list_request(input logic [2:0] req_kind, input logic [4:0] req_pos,
			input logic [31:0] req_word);
		list_result_t r;
		logic         is_full;
		logic         is_empty;
		int           i;
		r.status      = STATUS_OK;
		r.found       = 1'b0;
		r.found_index = '0;
		is_full       = (list_len >= LIST_DEPTH);
		is_empty      = (list_len == 0);
		case (req_kind)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (is_full)
					r.status = STATUS_FULL;
				else
					open_slot((req_kind == KIND_PUSH_BACK) ? list_len : 0, req_word);
			end
			KIND_POP_BACK: begin
				if (is_empty)
					r.status = STATUS_EMPTY;
				else
					list_len--;
			end
			KIND_POP_FRONT: begin
				if (is_empty)
					r.status = STATUS_EMPTY;
				else
					close_slot(0);
			end
			KIND_INSERT: begin
				if (is_full)
					r.status = STATUS_FULL;
				else if (int'(req_pos) > list_len)
					r.status = STATUS_BAD_POS;
				else
					open_slot(int'(req_pos), req_word);
			end
			KIND_ERASE: begin
				if (is_empty)
					r.status = STATUS_EMPTY;
				else if (int'(req_pos) >= list_len)
					r.status = STATUS_BAD_POS;
				else
					close_slot(int'(req_pos));
			end
			KIND_FIND: begin
				if (is_empty) begin
					r.status = STATUS_EMPTY;
				end else begin
					// first equal entry wins
					for (i = 0; i < list_len; i++) begin
						if (!r.found && list_words[i] == req_word) begin
							r.found       = 1'b1;
							r.found_index = i[3:0];
						end
					end
				end
			end
			default: begin
				// unused code: nothing changes
			end
		endcase
		r.count = list_len[4:0];
		results_due.push_back(r);
	endtask

	// Compare a result word with the oldest expectation, field by field
	task automatic check_result_word();
		list_result_t exp_word;
		if (results_due.size() == 0) begin
			$error("result word with no request waiting: status %0d count %0d", status, count);
			fail_count++;
		end else begin
			exp_word = results_due.pop_front();
			if (status !== exp_word.status) begin
				$error("status: expected %0d, actual %0d", exp_word.status, status);
				fail_count++;
			end
			if (found !== exp_word.found) begin
				$error("found: expected %0d, actual %0d", exp_word.found, found);
				fail_count++;
			end
			if (found_index !== exp_word.found_index) begin
				$error("found_index: expected %0d, actual %0d", exp_word.found_index,
					found_index);
				fail_count++;
			end
			if (count !== exp_word.count) begin
				$error("count: expected %0d, actual %0d", exp_word.count, count);
				fail_count++;
			end
		end
	endtask

	initial begin
		fail_count    = 0;
		pending_words = 0;
		list_len      = 0;
	end

	// Check results first: a word leaving this edge belongs to an earlier request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			results_due.delete();
		end else begin
			if (done)
				check_result_word();
			if (start && !busy)
				apply_list_request(kind, position, value);
		end
		pending_words = results_due.size();
	end

endmodule

// ===== test/tb_ordered_array_list_engine.sv =====
// Testbench top for the ordered array list engine: clock, reset and request stimulus.
// Depends on oale_pkg, ordered_array_list_engine and oale_result_checker.
module tb_ordered_array_list_engine;
	import oale_pkg::*;

	localparam logic [2:0] KIND_UNUSED  = 3'd7;
	localparam int         LIMIT_CYCLES = 200000;
	localparam int         PHASES       = 13;
	localparam int         PHASE_WORDS  = 50;

	// Bias of a random phase
	localparam int BIAS_FILL  = 0;
	localparam int BIAS_DRAIN = 1;
	localparam int BIAS_MIXED = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [4:0]  position = '0;
	logic [31:0] value = '0;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [3:0]  found_index;
	logic [4:0]  count;
	int          fail_count;
	int          pending_words;
	int          cycle_count = 0;
	logic        quiet_phase = 1'b0;
	logic [31:0] word_pool [8];

	ordered_array_list_engine i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.found      (found),
		.found_index(found_index),
		.count      (count)
	);

	oale_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.position     (position),
		.value        (value),
		.done         (done),
		.status       (status),
		.found        (found),
		.found_index  (found_index),
		.count        (count),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one request word at the falling edge and hold it until accepted
	task automatic send_request(input logic [2:0] k, input logic [4:0] p, input logic [31:0] v);
		int gap;
		gap = quiet_phase ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 10));
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    = 1'b1;
		kind     = k;
		position = p;
		value    = v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop start and wait for every outstanding result word
	task automatic hold_until_drained();
		start = 1'b0;
		while (pending_words != 0)
			@(negedge clk);
	endtask

	function automatic logic [2:0] pick_kind(input int bias);
		int roll;
		int add_cut;
		int remove_cut;
		roll       = $urandom_range(0, 99);
		add_cut    = (bias == BIAS_FILL) ? 60 : (bias == BIAS_DRAIN) ? 20 : 38;
		remove_cut = add_cut + ((bias == BIAS_FILL) ? 20 : (bias == BIAS_DRAIN) ? 60 : 38);
		if (roll < 1)
			return KIND_UNUSED;
		if (roll < add_cut) begin
			case ($urandom_range(0, 2))
				0:       return KIND_PUSH_BACK;
				1:       return KIND_PUSH_FRONT;
				default: return KIND_INSERT;
			endcase
		end
		if (roll < remove_cut) begin
			case ($urandom_range(0, 2))
				0:       return KIND_POP_BACK;
				1:       return KIND_POP_FRONT;
				default: return KIND_ERASE;
			endcase
		end
		return KIND_FIND;
	endfunction

	// Mostly low positions so that many land inside the list; a few reach the top bit
	function automatic logic [4:0] pick_position();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 5'($urandom_range(0, 8));
		if (roll < 94)
			return 5'($urandom_range(0, 16));
		return 5'($urandom_range(0, 31));
	endfunction

	// Reuse a small pool so finds hit often
	function automatic logic [31:0] pick_word();
		if ($urandom_range(0, 9) < 6)
			return word_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	initial begin
		int i;
		int p;
		int bias;

		word_pool[0] = 32'h0000_0000;
		word_pool[1] = 32'hFFFF_FFFF;
		word_pool[2] = 32'h7FFF_FFFF;
		word_pool[3] = 32'h8000_0000;
		for (i = 4; i < 8; i++)
			word_pool[i] = $urandom;

		// Hold reset, then release it at a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Requests on the empty list, emptiness ahead of a bad position
		send_request(KIND_POP_BACK, 5'd0, 32'd0);
		send_request(KIND_POP_FRONT, 5'd0, 32'd0);
		send_request(KIND_ERASE, 5'd31, 32'd0);
		send_request(KIND_FIND, 5'd0, 32'd0);

		// Extremes of the word, insert and erase at and beyond the boundaries
		send_request(KIND_PUSH_BACK, 5'd0, 32'h7FFF_FFFF);
		send_request(KIND_PUSH_FRONT, 5'd0, 32'h8000_0000);
		send_request(KIND_INSERT, 5'd1, 32'h0000_0000);
		send_request(KIND_INSERT, 5'd5, 32'h1234_5678);
		send_request(KIND_INSERT, 5'd3, 32'hFFFF_FFFF);
		send_request(KIND_FIND, 5'd0, 32'h8000_0000);
		send_request(KIND_FIND, 5'd0, 32'h1234_5678);
		send_request(KIND_ERASE, 5'd4, 32'd0);
		send_request(KIND_ERASE, 5'd3, 32'd0);
		send_request(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);

		// Fill to the top, then requests on the full list and removals at both ends
		for (i = 0; i < 13; i++)
			send_request(KIND_PUSH_BACK, 5'd0, 32'hA5A5_0000 + i);
		send_request(KIND_PUSH_BACK, 5'd0, 32'h0000_0001);
		send_request(KIND_PUSH_FRONT, 5'd0, 32'h0000_0001);
		send_request(KIND_INSERT, 5'd31, 32'h0000_0001);
		send_request(KIND_FIND, 5'd0, 32'hA5A5_000C);
		send_request(KIND_ERASE, 5'd15, 32'd0);
		send_request(KIND_ERASE, 5'd0, 32'd0);
		send_request(KIND_POP_FRONT, 5'd0, 32'd0);
		send_request(KIND_POP_BACK, 5'd0, 32'd0);
		hold_until_drained();

		// Random phases, biased in turn to fill, drain or mix; some with no idling at all
		for (p = 0; p < PHASES; p++) begin
			bias        = p % 3;
			quiet_phase = ($urandom_range(0, 2) == 0);
			for (i = 0; i < PHASE_WORDS; i++)
				send_request(pick_kind(bias), pick_position(), pick_word());
			if ($urandom_range(0, 1) == 0)
				hold_until_drained();
		end

		// Wait for the last result words and a short tail
		hold_until_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
